### hdl/argb_alpha_blend_pixel_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ARGB alpha blend block
// Implication and next-cycle implication checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ARGB_ALPHA_BLEND_PIXEL_TOP_ASSERT_SVH
`define ARGB_ALPHA_BLEND_PIXEL_TOP_ASSERT_SVH

// same-cycle implication
`define ABP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error("abp: assertion failed");

// next-cycle implication
`define ABP_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error("abp: assertion failed");

`endif

### hdl/abp_pkg.sv
// ----------------------------------------------------------------------------
// abp_pkg
// Shared types, constants and the divide-by-255 helper for the blend block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package abp_pkg;

	localparam int unsigned NUM_CH = 3;

	localparam logic [7:0]  CHAN_MAX = 8'hFF;
	localparam logic [15:0] ROUND    = 16'd128;

	typedef enum logic [0:0] {
		REG_BLEND_MODE = 1'b0,
		REG_ALPHA_ADD  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic       blend_mode;
		logic [7:0] alpha_add;
	} cfg_t;

	// floor(x / 255), exact for x below 65280
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage

`default_nettype wire

### hdl/abp_cfg_regs.sv
// ----------------------------------------------------------------------------
// abp_cfg_regs
// APB-style register file holding the blend mode and the alpha offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module abp_cfg_regs
	import abp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_BLEND_MODE: begin
					cfg_q.blend_mode <= pwdata[0];
				end
				REG_ALPHA_ADD: begin
					cfg_q.alpha_add <= pwdata[7:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BLEND_MODE: prdata = {31'b0, cfg_q.blend_mode};
			REG_ALPHA_ADD:  prdata = {24'b0, cfg_q.alpha_add};
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hdl/abp_blend_pipe.sv
// ----------------------------------------------------------------------------
// abp_blend_pipe
// Four-stage blend datapath: products, divide, second products, final mix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "argb_alpha_blend_pixel_top_assert.svh"

module abp_blend_pipe
	import abp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  cfg_t             cfg,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] src_argb,
	input  wire logic [31:0] dst_pixel,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [31:0] out_pixel,
	output logic             write_enable
);

	// stage-wise ready chain
	logic rdy1, rdy2, rdy3, rdy4;
	logic v_s1, v_s2, v_s3, v_s4;

	assign rdy4     = !v_s4 || !out_stall;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	// ---------------- stage 1: alpha decode and first products ----------------
	logic [8:0]  sa_sum;
	logic [7:0]  src_a, sa8, inv;
	logic        copy_c, skip_c;
	logic [15:0] da_num_c;
	logic [15:0] ssa_c  [NUM_CH];
	logic [15:0] dinv_c [NUM_CH];

	always_comb begin
		src_a  = src_argb[31:24];
		sa_sum = {1'b0, src_a} + {1'b0, cfg.alpha_add};
		if (cfg.blend_mode) begin
			copy_c = sa_sum >= {1'b0, CHAN_MAX};
			skip_c = sa_sum == 9'd0;
			sa8    = sa_sum[7:0];
		end else begin
			copy_c = src_a == CHAN_MAX;
			skip_c = src_a == 8'd0;
			sa8    = src_a;
		end
		inv      = CHAN_MAX - sa8;
		da_num_c = {8'b0, dst_pixel[31:24]} * {8'b0, inv} + ROUND;
		for (int c = 0; c < NUM_CH; c++) begin
			ssa_c[c]  = {8'b0, src_argb[8*c +: 8]} * {8'b0, sa8};
			dinv_c[c] = {8'b0, dst_pixel[8*c +: 8]} * {8'b0, inv};
		end
	end

	logic        mode_s1, copy_s1, skip_s1;
	logic [31:0] src_s1, dst_s1;
	logic [15:0] da_num_s1;
	logic [15:0] ssa_s1  [NUM_CH];
	logic [15:0] dinv_s1 [NUM_CH];

	// ---------------- stage 2: divide by 255 ----------------
	logic [7:0] da_c;
	logic [7:0] srnd_c [NUM_CH];
	logic [7:0] mix1_c [NUM_CH];

	always_comb begin
		da_c = div255(da_num_s1);
		for (int c = 0; c < NUM_CH; c++) begin
			srnd_c[c] = div255(ssa_s1[c] + ROUND);
			mix1_c[c] = div255(ssa_s1[c] + dinv_s1[c]);
		end
	end

	logic        mode_s2, copy_s2, skip_s2;
	logic [31:0] src_s2, dst_s2;
	logic [7:0]  da_s2;
	logic [7:0]  srnd_s2 [NUM_CH];
	logic [7:0]  mix1_s2 [NUM_CH];

	// ---------------- stage 3: destination times blended alpha ----------------
	logic [15:0] dd_c [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			dd_c[c] = {8'b0, dst_s2[8*c +: 8]} * {8'b0, da_s2} + ROUND;
		end
	end

	logic        mode_s3, copy_s3, skip_s3;
	logic [31:0] src_s3, dst_s3;
	logic [7:0]  da_s3;
	logic [7:0]  srnd_s3 [NUM_CH];
	logic [7:0]  mix1_s3 [NUM_CH];
	logic [15:0] dd_s3   [NUM_CH];

	// ---------------- stage 4: final mix and select ----------------
	logic [31:0] pix_c;
	logic        we_c, straight_c;
	logic [8:0]  sum_c [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			sum_c[c] = {1'b0, div255(dd_s3[c])} + {1'b0, srnd_s3[c]};
		end
		straight_c = 1'b0;
		if (skip_s3) begin
			pix_c = dst_s3;
			we_c  = 1'b0;
		end else if (copy_s3) begin
			pix_c = src_s3;
			we_c  = 1'b1;
		end else if (mode_s3) begin
			pix_c      = {8'b0, mix1_s3[2], mix1_s3[1], mix1_s3[0]};
			we_c       = 1'b1;
			straight_c = 1'b1;
		end else begin
			pix_c = {da_s3, sum_c[2][7:0], sum_c[1][7:0], sum_c[0][7:0]};
			we_c  = 1'b1;
		end
	end

	logic [31:0] pix_s4;
	logic        we_s4, straight_s4;

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// ---------------- payload, held while the stage stalls ----------------
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			mode_s1   <= cfg.blend_mode;
			copy_s1   <= copy_c;
			skip_s1   <= skip_c;
			src_s1    <= src_argb;
			dst_s1    <= dst_pixel;
			da_num_s1 <= da_num_c;
			ssa_s1    <= ssa_c;
			dinv_s1   <= dinv_c;
		end
		if (rdy2 && v_s1) begin
			mode_s2 <= mode_s1;
			copy_s2 <= copy_s1;
			skip_s2 <= skip_s1;
			src_s2  <= src_s1;
			dst_s2  <= dst_s1;
			da_s2   <= da_c;
			srnd_s2 <= srnd_c;
			mix1_s2 <= mix1_c;
		end
		if (rdy3 && v_s2) begin
			mode_s3 <= mode_s2;
			copy_s3 <= copy_s2;
			skip_s3 <= skip_s2;
			src_s3  <= src_s2;
			dst_s3  <= dst_s2;
			da_s3   <= da_s2;
			srnd_s3 <= srnd_s2;
			mix1_s3 <= mix1_s2;
			dd_s3   <= dd_c;
		end
		if (rdy4 && v_s3) begin
			pix_s4      <= pix_c;
			we_s4       <= we_c;
			straight_s4 <= straight_c;
		end
	end

	assign out_valid    = v_s4;
	assign out_pixel    = pix_s4;
	assign write_enable = we_s4;

	// ---------------- assertions ----------------
	`ABP_ASSERT_IMP(a_empty_head_ready, clk, arst_n, !v_s1, !in_stall)
	`ABP_ASSERT_NXT(a_accept_fills_s1, clk, arst_n, in_valid && !in_stall, v_s1)
	`ABP_ASSERT_NXT(a_s3_moves_on, clk, arst_n, v_s3 && rdy4, v_s4)
	`ABP_ASSERT_IMP(a_straight_alpha_zero, clk, arst_n, v_s4 && straight_s4,
		pix_s4[31:24] == 8'd0 && we_s4)

endmodule

`default_nettype wire

### hdl/argb_alpha_blend_pixel_top.sv
// ----------------------------------------------------------------------------
// argb_alpha_blend_pixel_top
// Blends source onto destination ARGB pixels, one per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with src_argb and dst_pixel; a transfer
//   happens on a rising edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with out_pixel and write_enable.
//   Registers over the APB-style port: blend_mode at 0x0, alpha_add at 0x4;
//   write them only while no pixel is in flight.
//   Pipeline: four register stages; a transferred pixel passes through s1, s2,
//   s3 and s4 in order and is offered on the output while it sits in s4.
//   Throughput: one pixel per clock while out_stall is low, set by the fully
//   pipelined datapath (products, divide by 255, second products, final mix).
//   Stall: each stage holds while the one after it is full and blocked, so
//   bubbles are squeezed out and in_stall rises only when all four are full.
//   Reset: clears all stage valid bits and both registers (mode 0, offset 0).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module argb_alpha_blend_pixel_top
	import abp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] src_argb,
	input  wire logic [31:0] dst_pixel,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [31:0] out_pixel,
	output logic             write_enable
);

	cfg_t cfg;

	abp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	abp_blend_pipe u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.src_argb     (src_argb),
		.dst_pixel    (dst_pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_pixel    (out_pixel),
		.write_enable (write_enable)
	);

endmodule

`default_nettype wire
